### rtl/btft_pkg.sv
// Package for the bidirectional TCP flow table.
// Holds the request, entry and result types, status codes and fixed constants.
// Used by btft_mem, btft_ctrl and bidirectional_tcp_flow_table_top; depends on nothing.
package btft_pkg;

   localparam logic        REQ_ACCOUNT  = 1'b0;
   localparam logic        REQ_READ     = 1'b1;
   localparam logic [15:0] ETHER_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [6:0]  IP_HDR_BYTES = 7'd20;
   localparam logic [31:0] PKT_MAX      = 32'hFFFF_FFFF;
   localparam logic [47:0] BYTE_MAX     = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IGNORED     = 3'd0,
      ST_FWD_MATCH   = 3'd1,
      ST_REV_MATCH   = 3'd2,
      ST_NEW_ENTRY   = 3'd3,
      ST_TABLE_FULL  = 3'd4,
      ST_READ_OK     = 3'd5,
      ST_READ_UNUSED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_APPEND,
      S_READ,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic        req_kind;
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] ip_total_length;
      logic [3:0]  tcp_header_words;
      logic [7:0]  read_index;
   } request_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] packets;
      logic [47:0] bytes;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  entry_index;
      logic [15:0] payload_length;
      entry_type   entry;
      logic [8:0]  flows_in_use;
   } result_type;

endpackage

### rtl/btft_mem.sv
// Flow entry memory: one write port and one read port with registered read data.
// Depends on btft_pkg for the entry type.
module btft_mem #(
   parameter int TABLE_DEPTH = 256,
   parameter int IDX_W       = 8
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output btft_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  btft_pkg::entry_type wr_data
);

   btft_pkg::entry_type mem [TABLE_DEPTH];
   btft_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/btft_ctrl.sv
// Sequencer of the flow table: classifies a request, scans the entry memory in order,
// then updates or appends an entry; a read reads its entry directly. All form a result.
// Depends on btft_pkg; drives the ports of btft_mem.
module btft_ctrl #(
   parameter int TABLE_DEPTH = 256,
   parameter int IDX_W       = 8,
   parameter int UC_W        = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  btft_pkg::request_type req,
   output logic                  res_valid,
   input  logic                  res_ready,
   output btft_pkg::result_type  res,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  btft_pkg::entry_type   rd_data,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output btft_pkg::entry_type   wr_data
);

   localparam int CMP_W = (UC_W > 9) ? UC_W : 9;

   btft_pkg::state_type  state_ff,  state_in;
   logic [UC_W-1:0]      used_ff,   used_in;
   logic [IDX_W-1:0]     scan_ff,   scan_in;
   logic [15:0]          pay_ff,    pay_in;
   logic [31:0]          sa_ff,     sa_in;
   logic [31:0]          da_ff,     da_in;
   logic [15:0]          sp_ff,     sp_in;
   logic [15:0]          dp_ff,     dp_in;
   logic [7:0]           ridx_ff,   ridx_in;
   btft_pkg::entry_type  hit_ff,    hit_in;
   btft_pkg::status_type hit_st_ff, hit_st_in;
   btft_pkg::result_type res_ff,    res_in;

   logic [6:0]           hdr_bytes;
   logic [15:0]          pay_calc;
   logic                 is_tcp;
   logic                 read_in_use;
   logic                 fwd_hit;
   logic                 rev_hit;
   logic                 scan_last;
   logic                 table_full;
   logic [48:0]          byte_sum;
   btft_pkg::entry_type  upd_entry;
   btft_pkg::entry_type  new_entry;
   btft_pkg::result_type res_base;

   assign hdr_bytes = btft_pkg::IP_HDR_BYTES + {1'b0, req.tcp_header_words, 2'b00};
   assign pay_calc  = (req.ip_total_length > {9'd0, hdr_bytes}) ?
                      (req.ip_total_length - {9'd0, hdr_bytes}) : 16'd0;
   assign is_tcp    = (req.eth_type == btft_pkg::ETHER_IPV4) &&
                      (req.ip_protocol == btft_pkg::PROTO_TCP);
   assign read_in_use = CMP_W'(req.read_index) < CMP_W'(used_ff);

   assign fwd_hit = (rd_data.src_addr == sa_ff) && (rd_data.dst_addr == da_ff) &&
                    (rd_data.src_port == sp_ff) && (rd_data.dst_port == dp_ff);
   assign rev_hit = (rd_data.src_addr == da_ff) && (rd_data.dst_addr == sa_ff) &&
                    (rd_data.src_port == dp_ff) && (rd_data.dst_port == sp_ff);
   assign scan_last  = (UC_W'(scan_ff) + 1'b1) == used_ff;
   assign table_full = used_ff == UC_W'(TABLE_DEPTH);

   assign byte_sum = {1'b0, hit_ff.bytes} + {33'd0, pay_ff};

   always_comb begin
      upd_entry         = hit_ff;
      upd_entry.packets = (hit_ff.packets == btft_pkg::PKT_MAX) ?
                          btft_pkg::PKT_MAX : hit_ff.packets + 32'd1;
      upd_entry.bytes   = byte_sum[48] ? btft_pkg::BYTE_MAX : byte_sum[47:0];
   end

   always_comb begin
      new_entry.src_addr = sa_ff;
      new_entry.dst_addr = da_ff;
      new_entry.src_port = sp_ff;
      new_entry.dst_port = dp_ff;
      new_entry.packets  = 32'd1;
      new_entry.bytes    = {32'd0, pay_ff};
   end

   always_comb begin
      res_base                = '0;
      res_base.status         = btft_pkg::ST_IGNORED;
      res_base.flows_in_use   = 9'(used_ff);
   end

   always_comb begin
      state_in  = state_ff;
      used_in   = used_ff;
      scan_in   = scan_ff;
      pay_in    = pay_ff;
      sa_in     = sa_ff;
      da_in     = da_ff;
      sp_in     = sp_ff;
      dp_in     = dp_ff;
      ridx_in   = ridx_ff;
      hit_in    = hit_ff;
      hit_st_in = hit_st_ff;
      res_in    = res_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = scan_ff;
      wr_data   = upd_entry;
      req_ready = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         btft_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sa_in   = req.src_ip;
               da_in   = req.dst_ip;
               sp_in   = req.src_port;
               dp_in   = req.dst_port;
               pay_in  = pay_calc;
               ridx_in = req.read_index;
               if (req.req_kind == btft_pkg::REQ_READ) begin
                  if (read_in_use) begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(req.read_index);
                     state_in = btft_pkg::S_READ;
                  end else begin
                     res_in             = res_base;
                     res_in.status      = btft_pkg::ST_READ_UNUSED;
                     res_in.entry_index = req.read_index;
                     state_in           = btft_pkg::S_RESULT;
                  end
               end else if (!is_tcp) begin
                  res_in   = res_base;
                  state_in = btft_pkg::S_RESULT;
               end else if (used_ff == '0) begin
                  state_in = btft_pkg::S_APPEND;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  scan_in  = '0;
                  state_in = btft_pkg::S_SCAN;
               end
            end
         end
         btft_pkg::S_SCAN: begin
            if (fwd_hit || rev_hit) begin
               hit_in    = rd_data;
               hit_st_in = fwd_hit ? btft_pkg::ST_FWD_MATCH : btft_pkg::ST_REV_MATCH;
               state_in  = btft_pkg::S_UPDATE;
            end else if (scan_last) begin
               if (table_full) begin
                  res_in                = res_base;
                  res_in.status         = btft_pkg::ST_TABLE_FULL;
                  res_in.payload_length = pay_ff;
                  state_in              = btft_pkg::S_RESULT;
               end else begin
                  state_in = btft_pkg::S_APPEND;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(scan_ff + 1'b1);
               scan_in = IDX_W'(scan_ff + 1'b1);
            end
         end
         btft_pkg::S_UPDATE: begin
            wr_en                 = 1'b1;
            wr_addr               = scan_ff;
            wr_data               = upd_entry;
            res_in.status         = hit_st_ff;
            res_in.entry_index    = 8'(scan_ff);
            res_in.payload_length = pay_ff;
            res_in.entry          = upd_entry;
            res_in.flows_in_use   = 9'(used_ff);
            state_in              = btft_pkg::S_RESULT;
         end
         btft_pkg::S_APPEND: begin
            wr_en                 = 1'b1;
            wr_addr               = IDX_W'(used_ff);
            wr_data               = new_entry;
            used_in               = UC_W'(used_ff + 1'b1);
            res_in.status         = btft_pkg::ST_NEW_ENTRY;
            res_in.entry_index    = 8'(used_ff);
            res_in.payload_length = pay_ff;
            res_in.entry          = new_entry;
            res_in.flows_in_use   = 9'(used_ff + 1'b1);
            state_in              = btft_pkg::S_RESULT;
         end
         btft_pkg::S_READ: begin
            res_in.status         = btft_pkg::ST_READ_OK;
            res_in.entry_index    = ridx_ff;
            res_in.payload_length = 16'd0;
            res_in.entry          = rd_data;
            res_in.flows_in_use   = 9'(used_ff);
            state_in              = btft_pkg::S_RESULT;
         end
         btft_pkg::S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = btft_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = btft_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btft_pkg::S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      pay_ff    <= pay_in;
      sa_ff     <= sa_in;
      da_ff     <= da_in;
      sp_ff     <= sp_in;
      dp_ff     <= dp_in;
      ridx_ff   <= ridx_in;
      hit_ff    <= hit_in;
      hit_st_ff <= hit_st_in;
      res_ff    <= res_in;
   end

   assign res = res_ff;

endmodule

### rtl/bidirectional_tcp_flow_table_top.sv
// Bidirectional TCP flow table, top level: sequencer, entry memory and output register.
// Depends on btft_pkg, btft_mem and btft_ctrl.
// An ignored frame or unused read index goes straight to the result; a read reads its entry,
// a frame that matches entry k scans entries 0 to k and updates it; a new or full-table frame
// scans every entry in use. The scan reads one entry per cycle from the single memory port.
// One request at a time; the next is taken the cycle after the result enters the output
// register. Reset empties the table at once (entry count to zero); entries are not cleared.
module bidirectional_tcp_flow_table_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_eth_type,
   input  logic [7:0]  req_ip_protocol,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [15:0] req_ip_total_length,
   input  logic [3:0]  req_tcp_header_words,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_entry_index,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_entry_src_addr,
   output logic [31:0] rsp_entry_dst_addr,
   output logic [15:0] rsp_entry_src_port,
   output logic [15:0] rsp_entry_dst_port,
   output logic [31:0] rsp_entry_packets,
   output logic [47:0] rsp_entry_bytes,
   output logic [8:0]  rsp_flows_in_use
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int UC_W  = $clog2(TABLE_DEPTH + 1);

   btft_pkg::request_type req;
   btft_pkg::result_type  res;
   btft_pkg::result_type  rsp_ff;
   btft_pkg::entry_type   rd_data;
   btft_pkg::entry_type   wr_data;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  res_valid;
   logic                  res_ready;
   logic                  rd_en;
   logic                  wr_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;

   always_comb begin
      req.req_kind         = req_type;
      req.eth_type         = req_eth_type;
      req.ip_protocol      = req_ip_protocol;
      req.src_ip           = req_src_ip;
      req.dst_ip           = req_dst_ip;
      req.src_port         = req_src_port;
      req.dst_port         = req_dst_port;
      req.ip_total_length  = req_ip_total_length;
      req.tcp_header_words = req_tcp_header_words;
      req.read_index       = req_read_index;
   end

   btft_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX_W      (IDX_W),
      .UC_W       (UC_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   btft_mem #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_entry_index    = rsp_ff.entry_index;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_entry_src_addr = rsp_ff.entry.src_addr;
   assign rsp_entry_dst_addr = rsp_ff.entry.dst_addr;
   assign rsp_entry_src_port = rsp_ff.entry.src_port;
   assign rsp_entry_dst_port = rsp_ff.entry.dst_port;
   assign rsp_entry_packets  = rsp_ff.entry.packets;
   assign rsp_entry_bytes    = rsp_ff.entry.bytes;
   assign rsp_flows_in_use   = rsp_ff.flows_in_use;

endmodule

### bench/tb_bidirectional_tcp_flow_table_top.sv
// Testbench for bidirectional_tcp_flow_table_top: directed frames and reads, then random flows.
// A scoreboard class keeps its own copy of the flow table and checks every result transfer.
// Depends on btft_pkg and the RTL of the flow table.
module tb_bidirectional_tcp_flow_table_top;

   localparam int FLOW_SLOTS   = 256;
   localparam int RANDOM_ITEMS = 1000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
   } flow_tuple_type;

   class flow_scoreboard;
      btft_pkg::entry_type  flows[FLOW_SLOTS];
      int unsigned          flows_used;
      btft_pkg::result_type awaited[$];
      int unsigned          fault_count;

      function new();
         flows_used  = 0;
         fault_count = 0;
      endfunction

      function string describe(btft_pkg::result_type v);
         return $sformatf("st=%0d idx=%0d pay=%0d sa=%h da=%h sp=%h dp=%h pk=%0d by=%0d fl=%0d",
                          v.status, v.entry_index, v.payload_length, v.entry.src_addr,
                          v.entry.dst_addr, v.entry.src_port, v.entry.dst_port,
                          v.entry.packets, v.entry.bytes, v.flows_in_use);
      endfunction

      function void note_request(btft_pkg::request_type r);
         btft_pkg::result_type res;
         int unsigned          hdr;
         int unsigned          pay;
         int unsigned          slot;
         int unsigned          i;
         btft_pkg::status_type found;
         logic [48:0]          sum;
         res = '0;
         if (r.req_kind == btft_pkg::REQ_READ) begin
            res.entry_index = r.read_index;
            if (r.read_index < flows_used) begin
               res.status = btft_pkg::ST_READ_OK;
               res.entry  = flows[r.read_index];
            end else begin
               res.status = btft_pkg::ST_READ_UNUSED;
            end
         end else if (r.eth_type == btft_pkg::ETHER_IPV4 &&
                      r.ip_protocol == btft_pkg::PROTO_TCP) begin
            hdr = btft_pkg::IP_HDR_BYTES + 4 * r.tcp_header_words;
            pay = (r.ip_total_length > hdr) ? r.ip_total_length - hdr : 0;
            res.payload_length = 16'(pay);
            found = btft_pkg::ST_IGNORED;
            slot  = 0;
            for (i = 0; i < flows_used; i++) begin
               if (found == btft_pkg::ST_IGNORED) begin
                  if (flows[i].src_addr == r.src_ip && flows[i].dst_addr == r.dst_ip &&
                      flows[i].src_port == r.src_port && flows[i].dst_port == r.dst_port) begin
                     found = btft_pkg::ST_FWD_MATCH;
                     slot  = i;
                  end else if (flows[i].src_addr == r.dst_ip && flows[i].dst_addr == r.src_ip &&
                               flows[i].src_port == r.dst_port &&
                               flows[i].dst_port == r.src_port) begin
                     found = btft_pkg::ST_REV_MATCH;
                     slot  = i;
                  end
               end
            end
            if (found != btft_pkg::ST_IGNORED) begin
               if (flows[slot].packets != btft_pkg::PKT_MAX) begin
                  flows[slot].packets = flows[slot].packets + 32'd1;
               end
               sum = {1'b0, flows[slot].bytes} + 49'(pay);
               flows[slot].bytes = (sum > {1'b0, btft_pkg::BYTE_MAX}) ?
                                   btft_pkg::BYTE_MAX : sum[47:0];
               res.status      = found;
               res.entry_index = 8'(slot);
               res.entry       = flows[slot];
            end else if (flows_used >= FLOW_SLOTS) begin
               res.status = btft_pkg::ST_TABLE_FULL;
            end else begin
               flows[flows_used].src_addr = r.src_ip;
               flows[flows_used].dst_addr = r.dst_ip;
               flows[flows_used].src_port = r.src_port;
               flows[flows_used].dst_port = r.dst_port;
               flows[flows_used].packets  = 32'd1;
               flows[flows_used].bytes    = 48'(pay);
               res.status      = btft_pkg::ST_NEW_ENTRY;
               res.entry_index = 8'(flows_used);
               res.entry       = flows[flows_used];
               flows_used++;
            end
         end
         res.flows_in_use = 9'(flows_used);
         awaited.push_back(res);
      endfunction

      function void check_result(btft_pkg::result_type got);
         btft_pkg::result_type want;
         if (awaited.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("Unexpected result transfer: %s", describe(got));
            end
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.entry_index !== want.entry_index ||
             got.payload_length !== want.payload_length ||
             got.entry.src_addr !== want.entry.src_addr ||
             got.entry.dst_addr !== want.entry.dst_addr ||
             got.entry.src_port !== want.entry.src_port ||
             got.entry.dst_port !== want.entry.dst_port ||
             got.entry.packets !== want.entry.packets ||
             got.entry.bytes !== want.entry.bytes ||
             got.flows_in_use !== want.flows_in_use) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("Mismatch: expected %s", describe(want));
               $display("          actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [15:0] req_eth_type;
   logic [7:0]  req_ip_protocol;
   logic [31:0] req_src_ip;
   logic [31:0] req_dst_ip;
   logic [15:0] req_src_port;
   logic [15:0] req_dst_port;
   logic [15:0] req_ip_total_length;
   logic [3:0]  req_tcp_header_words;
   logic [7:0]  req_read_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_entry_index;
   logic [15:0] rsp_payload_length;
   logic [31:0] rsp_entry_src_addr;
   logic [31:0] rsp_entry_dst_addr;
   logic [15:0] rsp_entry_src_port;
   logic [15:0] rsp_entry_dst_port;
   logic [31:0] rsp_entry_packets;
   logic [47:0] rsp_entry_bytes;
   logic [8:0]  rsp_flows_in_use;

   flow_scoreboard ledger;
   int             steady_left;
   flow_tuple_type known_flows[$];

   bidirectional_tcp_flow_table_top #(
      .TABLE_DEPTH(FLOW_SLOTS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_eth_type        (req_eth_type),
      .req_ip_protocol     (req_ip_protocol),
      .req_src_ip          (req_src_ip),
      .req_dst_ip          (req_dst_ip),
      .req_src_port        (req_src_port),
      .req_dst_port        (req_dst_port),
      .req_ip_total_length (req_ip_total_length),
      .req_tcp_header_words(req_tcp_header_words),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_entry_src_addr  (rsp_entry_src_addr),
      .rsp_entry_dst_addr  (rsp_entry_dst_addr),
      .rsp_entry_src_port  (rsp_entry_src_port),
      .rsp_entry_dst_port  (rsp_entry_dst_port),
      .rsp_entry_packets   (rsp_entry_packets),
      .rsp_entry_bytes     (rsp_entry_bytes),
      .rsp_flows_in_use    (rsp_flows_in_use)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      if (roll < 4) begin
         steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic btft_pkg::request_type random_req();
      btft_pkg::request_type r;
      r.req_kind         = 1'($urandom);
      r.eth_type         = 16'($urandom);
      r.ip_protocol      = 8'($urandom);
      r.src_ip           = $urandom;
      r.dst_ip           = $urandom;
      r.src_port         = 16'($urandom);
      r.dst_port         = 16'($urandom);
      r.ip_total_length  = 16'($urandom);
      r.tcp_header_words = 4'($urandom);
      r.read_index       = 8'($urandom);
      return r;
   endfunction

   function automatic btft_pkg::request_type frame_req(logic [31:0] sa, logic [31:0] da,
                                                       logic [15:0] sp, logic [15:0] dp,
                                                       logic [15:0] tlen, logic [3:0] words);
      btft_pkg::request_type r;
      r                  = random_req();
      r.req_kind         = btft_pkg::REQ_ACCOUNT;
      r.eth_type         = btft_pkg::ETHER_IPV4;
      r.ip_protocol      = btft_pkg::PROTO_TCP;
      r.src_ip           = sa;
      r.dst_ip           = da;
      r.src_port         = sp;
      r.dst_port         = dp;
      r.ip_total_length  = tlen;
      r.tcp_header_words = words;
      return r;
   endfunction

   function automatic btft_pkg::request_type read_req(logic [7:0] idx);
      btft_pkg::request_type r;
      r            = random_req();
      r.req_kind   = btft_pkg::REQ_READ;
      r.read_index = idx;
      return r;
   endfunction

   task automatic send_request(input btft_pkg::request_type r);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_type             <= r.req_kind;
      req_eth_type         <= r.eth_type;
      req_ip_protocol      <= r.ip_protocol;
      req_src_ip           <= r.src_ip;
      req_dst_ip           <= r.dst_ip;
      req_src_port         <= r.src_port;
      req_dst_port         <= r.dst_port;
      req_ip_total_length  <= r.ip_total_length;
      req_tcp_header_words <= r.tcp_header_words;
      req_read_index       <= r.read_index;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.note_request(r);
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   end

   initial begin
      btft_pkg::result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.status               = btft_pkg::status_type'(rsp_status);
            got.entry_index          = rsp_entry_index;
            got.payload_length       = rsp_payload_length;
            got.entry.src_addr       = rsp_entry_src_addr;
            got.entry.dst_addr       = rsp_entry_dst_addr;
            got.entry.src_port       = rsp_entry_src_port;
            got.entry.dst_port       = rsp_entry_dst_port;
            got.entry.packets        = rsp_entry_packets;
            got.entry.bytes          = rsp_entry_bytes;
            got.flows_in_use         = rsp_flows_in_use;
            ledger.check_result(got);
         end
      end
   end

   initial begin
      #(8 * 2_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      btft_pkg::request_type r;
      flow_tuple_type        t;
      int                    counted;
      int                    roll;
      ledger               = new();
      steady_left          = 0;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_type             = btft_pkg::REQ_ACCOUNT;
      req_eth_type         = '0;
      req_ip_protocol      = '0;
      req_src_ip           = '0;
      req_dst_ip           = '0;
      req_src_port         = '0;
      req_dst_port         = '0;
      req_ip_total_length  = '0;
      req_tcp_header_words = '0;
      req_read_index       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on an empty table: reads, ignored frames, all match kinds.
      send_request(read_req(8'd0));
      send_request(read_req(8'd255));
      r = frame_req(32'h0A00_0001, 32'h0A00_0002, 16'd1000, 16'd80, 16'd100, 4'd5);
      r.eth_type = 16'h86DD;
      send_request(r);
      r = frame_req(32'h0A00_0001, 32'h0A00_0002, 16'd1000, 16'd80, 16'd100, 4'd5);
      r.ip_protocol = 8'd17;
      send_request(r);
      r = frame_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
      r.eth_type    = 16'hFFFF;
      r.ip_protocol = 8'hFF;
      send_request(r);
      send_request(frame_req(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'hFFFF, 4'd0));
      send_request(frame_req(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd0, 4'hF));
      send_request(frame_req(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'd40, 4'd5));
      send_request(frame_req(32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80, 16'd100, 4'd5));
      send_request(frame_req(32'hC0A8_0001, 32'hC0A8_0001, 16'd80, 16'd80, 16'd60, 4'd8));
      send_request(frame_req(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'd81, 4'hF));
      send_request(frame_req(32'h1234_5678, 32'h9ABC_DEF0, 16'd1, 16'd2, 16'd20, 4'd0));
      send_request(frame_req(32'h1234_5678, 32'h9ABC_DEF0, 16'd1, 16'd3, 16'd21, 4'd0));
      send_request(frame_req(32'h9ABC_DEF0, 32'h1234_5678, 16'd1, 16'd2, 16'd1500, 4'd5));
      send_request(frame_req(32'h9ABC_DEF0, 32'h1234_5678, 16'd2, 16'd1, 16'hFFFF, 4'hF));
      send_request(read_req(8'd0));
      send_request(read_req(8'd4));
      send_request(read_req(8'd5));
      r = read_req(8'd2);
      r.eth_type         = 16'hFFFF;
      r.ip_protocol      = 8'hFF;
      r.src_ip           = 32'hFFFF_FFFF;
      r.ip_total_length  = 16'hFFFF;
      r.tcp_header_words = 4'hF;
      send_request(r);
      r = frame_req(32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd1, 4'd0);
      r.read_index = 8'hFF;
      send_request(r);

      // Random part: flows drawn from a growing set, seen both ways, for RANDOM_ITEMS requests.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            r = random_req();
            r.req_kind = btft_pkg::REQ_ACCOUNT;
            case ($urandom_range(0, 2))
               0: r.eth_type = btft_pkg::ETHER_IPV4;
               1: r.ip_protocol = btft_pkg::PROTO_TCP;
               default: ;
            endcase
            if (r.eth_type == btft_pkg::ETHER_IPV4 && r.ip_protocol == btft_pkg::PROTO_TCP) begin
               r.ip_protocol = r.ip_protocol ^ (8'd1 << $urandom_range(0, 7));
            end
            send_request(r);
            counted++;
         end else if (roll < 20) begin
            if (ledger.flows_used > 0 && $urandom_range(0, 9) < 7) begin
               send_request(read_req(8'($urandom_range(0, ledger.flows_used - 1))));
            end else begin
               send_request(read_req(8'($urandom)));
            end
            counted++;
         end else begin
            if (known_flows.size() == 0 || $urandom_range(0, 99) < 40) begin
               t.sa = $urandom;
               t.da = $urandom;
               t.sp = 16'($urandom);
               t.dp = 16'($urandom);
               case ($urandom_range(0, 9))
                  0: begin
                     if (known_flows.size() > 0) begin
                        t = known_flows[$urandom_range(0, known_flows.size() - 1)];
                        case ($urandom_range(0, 3))
                           0: t.sa = t.sa ^ (32'd1 << $urandom_range(0, 31));
                           1: t.da = t.da ^ (32'd1 << $urandom_range(0, 31));
                           2: t.sp = t.sp ^ (16'd1 << $urandom_range(0, 15));
                           default: t.dp = t.dp ^ (16'd1 << $urandom_range(0, 15));
                        endcase
                     end
                  end
                  1: begin
                     t.da = t.sa;
                     t.dp = t.sp;
                  end
                  default: ;
               endcase
               known_flows.push_back(t);
            end else begin
               t = known_flows[$urandom_range(0, known_flows.size() - 1)];
               if ($urandom_range(0, 1) == 1) begin
                  t = '{sa: t.da, da: t.sa, sp: t.dp, dp: t.sp};
               end
            end
            if ($urandom_range(0, 1) == 1) begin
               r = frame_req(t.sa, t.da, t.sp, t.dp, 16'($urandom_range(0, 100)),
                             4'($urandom));
            end else begin
               r = frame_req(t.sa, t.da, t.sp, t.dp, 16'($urandom), 4'($urandom));
            end
            send_request(r);
            counted++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (ledger.fault_count == 0 && ledger.awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
